[rtl/ilfc_pkg.sv]
package ilfc_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_PUSH   = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_POP    = 3'd3;
    localparam logic [2:0] REQ_LOOKUP = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int          FIB_W     = 10;
    localparam logic [3:0]  FIB_FLOOR = 4'd2;
    localparam logic [3:0]  FIB_TOP   = 4'd15;

    localparam logic [FIB_W-1:0] FIB_TABLE [16] = '{
        10'd1, 10'd1, 10'd1, 10'd2, 10'd3, 10'd5, 10'd8, 10'd13,
        10'd21, 10'd34, 10'd55, 10'd89, 10'd144, 10'd233, 10'd377, 10'd610
    };

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] value;
        logic        rd_en;
        logic        tap_en;
    } cell_ctl_t;

endpackage

[rtl/indexed_list_fibonacci_capacity.sv]
// Ordered list of signed 32-bit values with a Fibonacci-sized logical capacity.
// Request channel: req_valid/req_stall with req_type, position, item_value.
// Response channel: rsp_valid/rsp_stall with status, data_out, entry_count,
// logical_capacity; exactly one response transaction per request transaction.
// Entries live in a row of MAX_ENTRIES cells; insert and remove shift the cells
// at and above the addressed place by one place in the accepting cycle, so list
// state is current for the very next request.
// On the accept edge the cells update and the addressed entry is latched into
// per-cell taps; on the first advance after it (response register empty or
// being taken) the taps are ORed into the response register, raising rsp_valid.
// Throughput: one request per cycle while rsp_stall is low.
// When the receiver stalls, the response register holds and one more result
// waits in the tap stage; req_stall rises once both are occupied.
// Reset: empty list, capacity 1, no pending responses. Entries are not cleared.
module indexed_list_fibonacci_capacity #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  req_type,
    input  logic [7:0]  position,
    input  logic signed [31:0] item_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic signed [31:0] data_out,
    output logic [6:0]  entry_count,
    output logic [6:0]  logical_capacity
);
    import ilfc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int XW    = (CNT_W > FIB_W) ? CNT_W : FIB_W;
    localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);

    logic             accept;
    logic             advance;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [3:0]       fib_idx_reg;
    logic [3:0]       fib_idx_next;

    logic             a_valid_reg;
    logic [1:0]       a_status_reg;
    logic [6:0]       a_count_reg;
    logic [6:0]       a_cap_reg;

    logic             rsp_valid_reg;
    logic [1:0]       status_reg;
    logic [31:0]      data_reg;
    logic [6:0]       count_out_reg;
    logic [6:0]       cap_out_reg;

    logic [1:0]       st;
    logic             do_ins;
    logic             do_rem;
    logic             do_rd;
    logic [XW-1:0]    sel_x;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    cnt_after_x;
    logic [IDX_W-1:0] sel_pos;
    cell_ctl_t        ctl;

    logic [31:0]      cell_value [MAX_ENTRIES];
    logic [31:0]      cell_tap   [MAX_ENTRIES];
    logic [31:0]      tap_or;

    assign advance   = a_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = a_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign cnt_x = XW'(count_reg);
    assign pos_x = XW'(position);

    always_comb
    begin
        st     = ST_OK;
        do_ins = 1'b0;
        do_rem = 1'b0;
        do_rd  = 1'b0;
        sel_x  = pos_x;
        unique case (req_type)
            REQ_INSERT:
            begin
                if (pos_x > cnt_x)
                begin
                    st = ST_RANGE;
                end
                else if (cnt_x == MAX_X)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            REQ_PUSH:
            begin
                sel_x = cnt_x;
                if (cnt_x == MAX_X)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (pos_x >= cnt_x)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_rem = 1'b1;
                    do_rd  = 1'b1;
                end
            end
            REQ_POP:
            begin
                sel_x = cnt_x - XW'(1);
                if (cnt_x == '0)
                begin
                    st = ST_UNDERFLOW;
                end
                else
                begin
                    do_rem = 1'b1;
                    do_rd  = 1'b1;
                end
            end
            REQ_LOOKUP:
            begin
                if (pos_x >= cnt_x)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_rd = 1'b1;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign sel_pos = IDX_W'(sel_x);

    always_comb
    begin
        count_next   = count_reg;
        fib_idx_next = fib_idx_reg;
        cnt_after_x  = cnt_x;
        if (accept && do_ins)
        begin
            cnt_after_x = cnt_x + XW'(1);
            count_next  = CNT_W'(cnt_after_x);
            if ((cnt_after_x > XW'(FIB_TABLE[fib_idx_reg])) && (fib_idx_reg < FIB_TOP))
            begin
                fib_idx_next = fib_idx_reg + 4'd1;
            end
        end
        else if (accept && do_rem)
        begin
            cnt_after_x = cnt_x - XW'(1);
            count_next  = CNT_W'(cnt_after_x);
            if ((fib_idx_reg > FIB_FLOOR) &&
                (cnt_after_x < XW'(FIB_TABLE[fib_idx_reg - 4'd2])))
            begin
                fib_idx_next = fib_idx_reg - 4'd1;
            end
        end
    end

    always_comb
    begin
        ctl.op     = CELL_HOLD;
        ctl.value  = item_value;
        ctl.rd_en  = do_rd;
        ctl.tap_en = accept;
        if (accept && do_ins)
        begin
            ctl.op = CELL_INSERT;
        end
        else if (accept && do_rem)
        begin
            ctl.op = CELL_REMOVE;
        end
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [31:0] left_v;
        logic [31:0] right_v;
        if (i == 0)
        begin : g_first
            assign left_v = 32'd0;
        end
        else
        begin : g_left
            assign left_v = cell_value[i-1];
        end
        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign right_v = 32'd0;
        end
        else
        begin : g_right
            assign right_v = cell_value[i+1];
        end
        ilfc_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .sel_pos     (sel_pos),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .tap         (cell_tap[i])
        );
    end

    always_comb
    begin
        tap_or = 32'd0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            tap_or = tap_or | cell_tap[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fib_idx_reg   <= FIB_FLOOR;
            a_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            fib_idx_reg <= fib_idx_next;
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_status_reg <= st;
            a_count_reg  <= 7'(XW'(count_next));
            a_cap_reg    <= 7'(FIB_TABLE[fib_idx_next]);
        end
        if (advance)
        begin
            status_reg    <= a_status_reg;
            data_reg      <= tap_or;
            count_out_reg <= a_count_reg;
            cap_out_reg   <= a_cap_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign data_out         = data_reg;
    assign entry_count      = count_out_reg;
    assign logical_capacity = cap_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= MAX_X)
        else $error("entry count above store bound");

    a_fib_floor: assert property (@(posedge clk) disable iff (!rst_n)
        fib_idx_reg >= FIB_FLOOR)
        else $error("fibonacci index below floor");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != ST_OK)) |-> (data_out == 32'd0))
        else $error("failed transaction carries data");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && rsp_valid_reg && rsp_stall) |-> req_stall)
        else $error("request taken with both result stages occupied");

endmodule

[rtl/ilfc_cell.sv]
module ilfc_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic              clk,
    input  ilfc_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]  sel_pos,
    input  logic [31:0]       left_value,
    input  logic [31:0]       right_value,
    output logic [31:0]       value,
    output logic [31:0]       tap
);
    import ilfc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic [31:0] tap_reg;

    always_comb
    begin
        value_next = value_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (MY_IDX > sel_pos)
                begin
                    value_next = left_value;
                end
                else if (MY_IDX == sel_pos)
                begin
                    value_next = ctl.value;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= sel_pos)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (ctl.tap_en)
        begin
            tap_reg <= (ctl.rd_en && (MY_IDX == sel_pos)) ? value_reg : 32'd0;
        end
    end

    assign value = value_reg;
    assign tap   = tap_reg;

endmodule
